@@ rtl/core/swxre_pkg.sv @@
// ---------------------------------------------------------------------------
// swxre_pkg
// Shared types and constants of the sliding-window XOR repair encoder.
// ---------------------------------------------------------------------------
`default_nettype none
package swxre_pkg;

  localparam int unsigned WCNT_W  = 5;
  localparam int unsigned IVL_W   = 8;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned BYTES_W = 4;
  localparam int unsigned SEQ_W   = 32;

  localparam logic CFG_WINDOW_COUNT    = 1'b0;
  localparam logic CFG_REPAIR_INTERVAL = 1'b1;

  localparam logic [WCNT_W-1:0] WCNT_RESET = 5'd16;
  localparam logic [IVL_W-1:0]  IVL_RESET  = 8'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_LEN,
    ST_RD,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic init;
    logic len_step;
    logic rd;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic due;
    logic len_done;
    logic slots_done;
    logic w_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/core/swxre_if.sv @@
// ---------------------------------------------------------------------------
// swxre_src_if / swxre_res_if
// Source-word and result-word channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none
interface swxre_src_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last_word;
  modport source (output valid, data_word, byte_count, last_word, input ready);
  modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface swxre_res_if;
  logic        valid;
  logic        ready;
  logic        repair_flag;
  logic [31:0] seq_number;
  logic [63:0] out_word;
  logic [3:0]  out_bytes;
  logic        packet_end;
  logic [31:0] oldest_covered;
  logic [4:0]  covered_count;
  logic        run_end;
  modport source (output valid, repair_flag, seq_number, out_word, out_bytes, packet_end,
                  oldest_covered, covered_count, run_end, input ready);
  modport sink   (input valid, repair_flag, seq_number, out_word, out_bytes, packet_end,
                  oldest_covered, covered_count, run_end, output ready);
endinterface
`default_nettype wire

@@ rtl/core/swxre_ctrl.sv @@
// ---------------------------------------------------------------------------
// swxre_ctrl
// Sequencer: echo, window length scan, per-word slot sweep and emit.
// ---------------------------------------------------------------------------
`default_nettype none
module swxre_ctrl
  import swxre_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid && sts.out_free && sts.due) state_next = ST_INIT;
      ST_INIT: state_next = ST_LEN;
      ST_LEN:  if (sts.len_done) state_next = ST_RD;
      ST_RD:   state_next = ST_ACC;
      ST_ACC:  state_next = sts.slots_done ? ST_EMIT : ST_RD;
      ST_EMIT: if (sts.out_free) state_next = sts.w_last ? ST_IDLE : ST_RD;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = sts.out_free;
        cmd.accept = in_valid && sts.out_free;
      end
      ST_INIT: cmd.init     = 1'b1;
      ST_LEN:  cmd.len_step = 1'b1;
      ST_RD:   cmd.rd       = 1'b1;
      ST_ACC:  cmd.acc      = 1'b1;
      ST_EMIT: cmd.emit     = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/swxre_dpath.sv @@
// ---------------------------------------------------------------------------
// swxre_dpath
// Window store, slot tables, counters, XOR accumulator and result register.
// ---------------------------------------------------------------------------
`default_nettype none
module swxre_dpath
  import swxre_pkg::*;
#(
  parameter int WINDOW    = 16,
  parameter int MAX_WORDS = 32
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_we,
  input  wire                 cfg_index,
  input  wire [CFG_W-1:0]     cfg_data,
  input  wire [DATA_W-1:0]    data_word,
  input  wire [BYTES_W-1:0]   byte_count,
  input  wire                 last_word,
  input  cmd_t                cmd,
  output status_t             sts,
  input  wire                 res_ready,
  output logic                res_valid,
  output logic                repair_flag,
  output logic [SEQ_W-1:0]    seq_number,
  output logic [DATA_W-1:0]   out_word,
  output logic [BYTES_W-1:0]  out_bytes,
  output logic                packet_end,
  output logic [SEQ_W-1:0]    oldest_covered,
  output logic [WCNT_W-1:0]   covered_count,
  output logic                run_end
);

  localparam int SW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int WW    = $clog2(MAX_WORDS + 1);
  localparam int LW    = $clog2(MAX_WORDS * 8 + 1);
  localparam int DEPTH = WINDOW * MAX_WORDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;

  logic [LW-1:0]    slot_length [WINDOW];
  logic [SEQ_W-1:0] slot_seq    [WINDOW];

  logic [WCNT_W-1:0] window_count;
  logic [IVL_W-1:0]  repair_interval;
  logic [FW-1:0]     fill_count;
  logic [SW-1:0]     write_slot;
  logic [WW-1:0]     word_index;
  logic [IVL_W-1:0]  repair_counter;
  logic [SEQ_W-1:0]  next_seq;

  logic [WCNT_W-1:0] cov;
  logic [SW-1:0]     oldest;
  logic [SEQ_W-1:0]  rep_seq;
  logic [WCNT_W-1:0] k;
  logic [SW-1:0]     cur;
  logic [LW-1:0]     len;
  logic [WW-1:0]     w;
  logic [DATA_W-1:0] acc;
  logic              use_q;

  logic [BYTES_W-1:0] bc;
  logic [DATA_W-1:0]  word_m;
  logic [IVL_W-1:0]   rc_inc;
  logic [WCNT_W-1:0]  wc_eff, cov_c;
  logic [SW-1:0]      oldest_c, cur_inc, slot_inc;
  logic [WW-1:0]      nwords;
  logic [LW-1:0]      len_rem;
  logic [BYTES_W-1:0] rep_bytes;
  int                 o;

  always_comb begin
    bc = byte_count;
    if (byte_count == '0) bc = BYTES_W'(1);
    else if (byte_count > BYTES_W'(8)) bc = BYTES_W'(8);
    for (int i = 0; i < 8; i++) begin
      word_m[i*8 +: 8] = (BYTES_W'(i) < bc) ? data_word[i*8 +: 8] : 8'h00;
    end
    rc_inc = (repair_counter == '1) ? repair_counter : repair_counter + IVL_W'(1);
    sts.due = last_word && (rc_inc >= repair_interval);

    wc_eff = window_count;
    if (window_count == '0) wc_eff = WCNT_W'(1);
    else if (int'(window_count) > WINDOW) wc_eff = WCNT_W'(WINDOW);
    cov_c = (int'(fill_count) < int'(wc_eff)) ? WCNT_W'(fill_count) : wc_eff;
    o = int'(write_slot) - int'(cov_c);
    if (o < 0) o = o + WINDOW;
    oldest_c = SW'(o);

    cur_inc  = (int'(cur) == WINDOW - 1) ? '0 : cur + SW'(1);
    slot_inc = (int'(write_slot) == WINDOW - 1) ? '0 : write_slot + SW'(1);

    nwords  = WW'((len + LW'(7)) >> 3);
    len_rem = len - LW'({w, 3'b000});
    sts.w_last = (nwords == '0) || (w + WW'(1) == nwords);
    if (len == '0)   rep_bytes = BYTES_W'(1);
    else if (sts.w_last) rep_bytes = BYTES_W'(len_rem);
    else             rep_bytes = BYTES_W'(8);

    sts.len_done   = (k + WCNT_W'(1) == cov);
    sts.slots_done = (k == cov);
    sts.out_free   = !res_valid || res_ready;
  end

  // window store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept && (int'(word_index) < MAX_WORDS))
      mem[AW'(int'(write_slot) * MAX_WORDS + int'(word_index))] <= word_m;
    if (cmd.rd)
      rdata <= mem[AW'(int'(cur) * MAX_WORDS + int'(w))];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count    <= WCNT_RESET;
      repair_interval <= IVL_RESET;
      fill_count      <= '0;
      write_slot      <= '0;
      word_index      <= '0;
      repair_counter  <= '0;
      next_seq        <= '0;
      res_valid       <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        slot_length[i] <= '0;
        slot_seq[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WINDOW_COUNT) window_count <= cfg_data[WCNT_W-1:0];
        else                               repair_interval <= cfg_data;
      end
      // load on accept or emit, otherwise drop once taken
      if (cmd.accept || cmd.emit) res_valid <= 1'b1;
      else if (res_ready)         res_valid <= 1'b0;
      if (cmd.accept) begin
        if (int'(word_index) < MAX_WORDS)
          slot_length[write_slot] <= LW'({word_index, 3'b000}) + LW'(bc);
        if (last_word) begin
          slot_seq[write_slot] <= next_seq;
          next_seq   <= next_seq + SEQ_W'(1);
          write_slot <= slot_inc;
          if (int'(fill_count) < WINDOW) fill_count <= fill_count + FW'(1);
          word_index <= '0;
          repair_counter <= sts.due ? '0 : rc_inc;
        end else if (int'(word_index) < MAX_WORDS) begin
          word_index <= word_index + WW'(1);
        end
      end
      if (cmd.init) next_seq <= next_seq + SEQ_W'(1);
    end
  end

  // repair sweep registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      repair_flag    <= 1'b0;
      seq_number     <= next_seq;
      out_word       <= word_m;
      out_bytes      <= bc;
      packet_end     <= last_word;
      oldest_covered <= '0;
      covered_count  <= '0;
      run_end        <= !sts.due;
    end
    if (cmd.init) begin
      cov     <= cov_c;
      oldest  <= oldest_c;
      cur     <= oldest_c;
      rep_seq <= next_seq;
      k       <= '0;
      len     <= '0;
    end
    if (cmd.len_step) begin
      if (slot_length[cur] > len) len <= slot_length[cur];
      if (sts.len_done) begin
        k   <= '0;
        cur <= oldest;
        w   <= '0;
        acc <= '0;
      end else begin
        k   <= k + WCNT_W'(1);
        cur <= cur_inc;
      end
    end
    if (cmd.rd) begin
      use_q <= LW'({w, 3'b000}) < slot_length[cur];
      cur   <= cur_inc;
      k     <= k + WCNT_W'(1);
    end
    if (cmd.acc && use_q) acc <= acc ^ rdata;
    if (cmd.emit) begin
      repair_flag    <= 1'b1;
      seq_number     <= rep_seq;
      out_word       <= acc;
      out_bytes      <= rep_bytes;
      packet_end     <= sts.w_last;
      oldest_covered <= slot_seq[oldest];
      covered_count  <= cov;
      run_end        <= sts.w_last;
      acc            <= '0;
      k              <= '0;
      cur            <= oldest;
      w              <= w + WW'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sliding_window_xor_repair_encoder_core.sv @@
// ---------------------------------------------------------------------------
// sliding_window_xor_repair_encoder_core
// Source word echo with periodic sliding-window XOR repair packets.
// ---------------------------------------------------------------------------
// Usage:
//   src carries source packets one 64-bit word per item (byte count, last
//   marker); res carries results. Every accepted word is echoed as one item
//   in the next cycle, tagged with its packet's sequence number, so source
//   words stream at one per cycle while the result register drains and no
//   repair is under way. When a closing word brings the closed-packet
//   counter to repair_interval, a repair packet follows the echo: set-up,
//   a scan of the covered slots for the longest covered packet, then per
//   repair word one store read per covered slot through the single read
//   port of the window store, XORed in where that packet reaches the word,
//   and emit. src stays low-ready until the last repair word is loaded.
//   A stalled receiver holds the result register; nothing is dropped.
//   Configuration (window_count, repair_interval) is written through
//   cfg_we/cfg_index/cfg_data; the user must do so while the block is idle,
//   which the block does not enforce. Synchronous reset clears counters, slot
//   tables and sequence numbers; window_count goes to 16, repair_interval to 4.
// ---------------------------------------------------------------------------
`default_nettype none
module sliding_window_xor_repair_encoder_core
  import swxre_pkg::*;
#(
  parameter int WINDOW    = 16,
  parameter int MAX_WORDS = 32
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             cfg_we,
  input  wire             cfg_index,
  input  wire [CFG_W-1:0] cfg_data,
  swxre_src_if.sink       src,
  swxre_res_if.source     res
);

  cmd_t    cmd;
  status_t sts;

  // sequencer: owns the handshake towards the source
  swxre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (src.valid),
    .in_ready (src.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, counters and result register
  swxre_dpath #(
    .WINDOW    (WINDOW),
    .MAX_WORDS (MAX_WORDS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .data_word      (src.data_word),
    .byte_count     (src.byte_count),
    .last_word      (src.last_word),
    .cmd            (cmd),
    .sts            (sts),
    .res_ready      (res.ready),
    .res_valid      (res.valid),
    .repair_flag    (res.repair_flag),
    .seq_number     (res.seq_number),
    .out_word       (res.out_word),
    .out_bytes      (res.out_bytes),
    .packet_end     (res.packet_end),
    .oldest_covered (res.oldest_covered),
    .covered_count  (res.covered_count),
    .run_end        (res.run_end)
  );

endmodule
`default_nettype wire
